// ===== hw/rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int unsigned PollW = 10;
  localparam int unsigned HoldW = 4;
  localparam int unsigned PhaseW = 5;

  localparam logic [PollW-1:0] PollLimitReset = 10'd500;
  localparam logic [HoldW-1:0] StartHoldReset = 4'd4;
  localparam logic [HoldW-1:0] BitPhaseReset = 4'd2;
  localparam logic [HoldW-1:0] ErrPauseLast = 4'd4;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_SUPPLY = 2'd2;

  localparam logic [1:0] CFG_POLL = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_BIT = 2'd2;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        sda_in;
    logic        is_read;
    logic [7:0]  dev_address;
    logic [15:0] reg_address;
    logic        addr_two_bytes;
    logic [7:0]  length;
    logic [7:0]  wr_byte;
  } in_word_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
    logic        need_write_byte;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        rd_last;
    logic        done_res;
    logic        status;
    logic        busy_res;
  } out_word_t;

  // front-end classified word
  typedef struct packed {
    logic        is_tick;
    logic        is_begin;
    logic        is_supply;
    logic        sda_in;
    logic        is_read;
    logic [7:0]  dev_address;
    logic [15:0] reg_address;
    logic        two_bytes;
    logic [7:0]  length;
    logic [7:0]  wr_byte;
  } cmd_t;

endpackage

// ===== hw/rtl/i2cm_if.sv =====
interface i2cm_in_if;
  i2cm_pkg::in_word_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
  i2cm_pkg::out_word_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
  logic [1:0]  index;
  logic [15:0] wdata;
  logic valid;
  logic ready;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/i2cm_front.sv =====
module i2cm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cm_pkg::in_word_t   in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  output i2cm_pkg::cmd_t       q_data
);
  import i2cm_pkg::*;

  cmd_t mem_r [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QueueDepth+1)-1:0] cnt_r, cnt_nxt;
  cmd_t cls;
  logic push, pop;

  always_comb begin
    cls.is_tick = in_data.kind == KIND_TICK;
    cls.is_begin = in_data.kind == KIND_BEGIN;
    cls.is_supply = in_data.kind == KIND_SUPPLY;
    cls.sda_in = in_data.sda_in;
    cls.is_read = in_data.is_read;
    cls.dev_address = in_data.dev_address;
    cls.reg_address = in_data.reg_address;
    cls.two_bytes = in_data.addr_two_bytes;
    cls.length = in_data.length;
    cls.wr_byte = in_data.wr_byte;
  end

  assign in_ready = cnt_r != ($clog2(QueueDepth+1))'(QueueDepth);
  assign q_valid = cnt_r != '0;
  assign q_data = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
  end
endmodule

// ===== hw/rtl/i2cm_back.sv =====
module i2cm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  i2cm_pkg::cmd_t       q_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [15:0]          cfg_val,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cm_pkg::out_word_t  out_data
);
  import i2cm_pkg::*;

  localparam logic [4:0] PH_IDLE = 5'd0, PH_ST_A = 5'd1, PH_ST_B = 5'd2,
    PH_WB_SET = 5'd3, PH_WB_HIGH = 5'd4, PH_WB_LOW = 5'd5, PH_ACK_REL = 5'd6,
    PH_ACK_CLK = 5'd7, PH_ACK_POLL = 5'd8, PH_WAIT_DATA = 5'd9,
    PH_RB_LOW = 5'd10, PH_RB_HIGH = 5'd11, PH_RA_SET = 5'd12,
    PH_RA_HIGH = 5'd13, PH_SP_A = 5'd14, PH_SP_B = 5'd15, PH_ERR_WAIT = 5'd16;
  localparam logic [2:0] ST_DEV = 3'd0, ST_HI = 3'd1, ST_LO = 3'd2,
    ST_RDEV = 3'd3, ST_DATA = 3'd4;

  logic [PollW-1:0] poll_lim_r;
  logic [HoldW-1:0] start_r, bitph_r;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt, dly_r, dly_nxt;
  logic [PollW-1:0] poll_r, poll_nxt;
  logic [7:0] sh_r, sh_nxt, left_r, left_nxt, dev_r, dev_nxt;
  logic [15:0] reg_r, reg_nxt;
  logic [1:0] flags_r, flags_nxt;
  logic scl_r, scl_nxt, sda_r, sda_nxt, drv_r, drv_nxt;
  logic [2:0] stage_r, stage_nxt;
  logic err_r, err_nxt;
  logic rdv, rdl, done, stat;
  logic [7:0] rdb;
  logic go;
  out_word_t res;

  assign q_ready = !out_valid || out_ready;
  assign go = q_valid && q_ready;

  function automatic logic [3:0] nzm1(input logic [3:0] v);
    return (v == 4'd0) ? 4'd0 : v - 4'd1;
  endfunction

  always_comb begin
    logic [4:0] tgt;
    logic do_enter;
    logic [3:0] bc;
    phase_nxt = phase_r; bit_nxt = bit_r; dly_nxt = dly_r; poll_nxt = poll_r;
    sh_nxt = sh_r; left_nxt = left_r; dev_nxt = dev_r; reg_nxt = reg_r;
    flags_nxt = flags_r; scl_nxt = scl_r; sda_nxt = sda_r; drv_nxt = drv_r;
    stage_nxt = stage_r; err_nxt = err_r;
    rdv = 1'b0; rdb = '0; rdl = 1'b0; done = 1'b0; stat = 1'b0;
    tgt = PH_IDLE; do_enter = 1'b0; bc = bit_r + 4'd1;
    if (q_data.is_begin && phase_r == PH_IDLE) begin
      dev_nxt = q_data.dev_address;
      reg_nxt = q_data.reg_address;
      flags_nxt = {q_data.two_bytes, q_data.is_read};
      left_nxt = (q_data.is_read && q_data.length == 8'd0) ? 8'd1 : q_data.length;
      err_nxt = 1'b0; stage_nxt = ST_DEV;
      tgt = PH_ST_A; do_enter = 1'b1;
    end else if (q_data.is_supply && phase_r == PH_WAIT_DATA) begin
      sh_nxt = q_data.wr_byte; bit_nxt = '0; stage_nxt = ST_DATA;
      tgt = PH_WB_SET; do_enter = 1'b1;
    end else if (q_data.is_tick && phase_r != PH_IDLE && phase_r != PH_WAIT_DATA) begin
      if (phase_r == PH_ACK_POLL) begin
        if (!q_data.sda_in) begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; drv_nxt = 1'b0;
          unique case (stage_r)
            ST_DEV: begin
              bit_nxt = '0; tgt = PH_WB_SET; do_enter = 1'b1;
              if (flags_r[1]) begin sh_nxt = reg_r[15:8]; stage_nxt = ST_HI; end
              else begin sh_nxt = reg_r[7:0]; stage_nxt = ST_LO; end
            end
            ST_HI: begin
              bit_nxt = '0; tgt = PH_WB_SET; do_enter = 1'b1;
              sh_nxt = reg_r[7:0]; stage_nxt = ST_LO;
            end
            ST_LO: begin
              do_enter = 1'b1;
              if (flags_r[0]) begin stage_nxt = ST_RDEV; tgt = PH_ST_A; end
              else if (left_r != 8'd0) begin stage_nxt = ST_DATA; tgt = PH_WAIT_DATA; end
              else tgt = PH_SP_A;
            end
            ST_RDEV: begin
              bit_nxt = '0; sh_nxt = '0; tgt = PH_RB_LOW; do_enter = 1'b1;
            end
            default: begin
              left_nxt = left_r - 8'd1; do_enter = 1'b1;
              tgt = (left_nxt != 8'd0) ? PH_WAIT_DATA : PH_SP_A;
            end
          endcase
        end else if (poll_r >= poll_lim_r) begin
          err_nxt = 1'b1; tgt = PH_SP_A; do_enter = 1'b1;
        end else begin
          poll_nxt = poll_r + 1'b1;
        end
      end else if (phase_r == PH_RB_HIGH) begin
        sh_nxt = {sh_r[6:0], q_data.sda_in};
        bit_nxt = bc; do_enter = 1'b1;
        if (bc >= 4'd8) begin
          rdv = 1'b1; rdb = sh_nxt; rdl = left_r <= 8'd1; tgt = PH_RA_SET;
        end else tgt = PH_RB_LOW;
      end else if (dly_r != 4'd0) begin
        dly_nxt = dly_r - 4'd1;
      end else begin
        do_enter = 1'b1;
        unique case (phase_r)
          PH_ST_A: tgt = PH_ST_B;
          PH_ST_B: begin
            bit_nxt = '0; tgt = PH_WB_SET;
            if (stage_r == ST_RDEV) sh_nxt = dev_r | 8'd1;
            else begin sh_nxt = dev_r; stage_nxt = ST_DEV; end
          end
          PH_WB_SET: tgt = PH_WB_HIGH;
          PH_WB_HIGH: tgt = PH_WB_LOW;
          PH_WB_LOW: begin
            sh_nxt = {sh_r[6:0], 1'b0}; bit_nxt = bc;
            tgt = (bc >= 4'd8) ? PH_ACK_REL : PH_WB_SET;
          end
          PH_ACK_REL: tgt = PH_ACK_CLK;
          PH_ACK_CLK: tgt = PH_ACK_POLL;
          PH_RB_LOW: tgt = PH_RB_HIGH;
          PH_RA_SET: tgt = PH_RA_HIGH;
          PH_RA_HIGH: begin
            left_nxt = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;
            if (left_nxt != 8'd0) begin bit_nxt = '0; sh_nxt = '0; tgt = PH_RB_LOW; end
            else tgt = PH_SP_A;
          end
          PH_SP_A: tgt = PH_SP_B;
          PH_SP_B: begin
            if (err_r) tgt = PH_ERR_WAIT;
            else begin done = 1'b1; tgt = PH_IDLE; end
          end
          default: begin
            done = 1'b1; stat = 1'b1; err_nxt = 1'b0; tgt = PH_IDLE;
          end
        endcase
      end
    end
    if (do_enter) begin
      phase_nxt = tgt; dly_nxt = '0;
      unique case (tgt)
        PH_ST_A: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1; dly_nxt = nzm1(start_r);
        end
        PH_ST_B: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0; drv_nxt = 1'b1; dly_nxt = nzm1(start_r);
        end
        PH_WB_SET: begin
          scl_nxt = 1'b0; sda_nxt = sh_nxt[7]; drv_nxt = 1'b1; dly_nxt = nzm1(bitph_r);
        end
        PH_WB_HIGH: begin scl_nxt = 1'b1; dly_nxt = nzm1(bitph_r); end
        PH_WB_LOW: begin scl_nxt = 1'b0; dly_nxt = nzm1(bitph_r); end
        PH_ACK_REL: begin scl_nxt = 1'b0; sda_nxt = 1'b1; drv_nxt = 1'b0; end
        PH_ACK_CLK: begin scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b0; end
        PH_ACK_POLL: poll_nxt = '0;
        PH_WAIT_DATA: begin scl_nxt = 1'b0; sda_nxt = 1'b1; drv_nxt = 1'b0; end
        PH_RB_LOW: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; drv_nxt = 1'b0; dly_nxt = nzm1(bitph_r);
        end
        PH_RB_HIGH: begin scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b0; end
        PH_RA_SET: begin
          scl_nxt = 1'b0; sda_nxt = left_nxt == 8'd1; drv_nxt = 1'b1;
          dly_nxt = nzm1(bitph_r);
        end
        PH_RA_HIGH: begin scl_nxt = 1'b1; dly_nxt = nzm1(bitph_r); end
        PH_SP_A: begin
          scl_nxt = 1'b0; sda_nxt = 1'b0; drv_nxt = 1'b1; dly_nxt = nzm1(start_r);
        end
        PH_SP_B: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1; dly_nxt = nzm1(start_r);
        end
        PH_ERR_WAIT: dly_nxt = ErrPauseLast;
        default: begin
          phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1;
        end
      endcase
    end
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.sda_drive = drv_nxt;
    res.need_write_byte = phase_nxt == PH_WAIT_DATA;
    res.rd_valid = rdv;
    res.rd_byte = rdb;
    res.rd_last = rdl;
    res.done_res = done;
    res.status = stat;
    res.busy_res = phase_nxt != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= res;
      bit_r <= bit_nxt; dly_r <= dly_nxt; poll_r <= poll_nxt; sh_r <= sh_nxt;
      left_r <= left_nxt; dev_r <= dev_nxt; reg_r <= reg_nxt;
    end
    if (!rst_n) begin
      out_valid <= 1'b0;
      poll_lim_r <= PollLimitReset; start_r <= StartHoldReset; bitph_r <= BitPhaseReset;
      phase_r <= PH_IDLE; flags_r <= '0; stage_r <= ST_DEV; err_r <= 1'b0;
      scl_r <= 1'b1; sda_r <= 1'b1; drv_r <= 1'b1;
      bit_r <= '0; dly_r <= '0; poll_r <= '0; sh_r <= '0; left_r <= '0;
      dev_r <= '0; reg_r <= '0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
        phase_r <= phase_nxt; flags_r <= flags_nxt; stage_r <= stage_nxt;
        err_r <= err_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt; drv_r <= drv_nxt;
      end else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_POLL: poll_lim_r <= cfg_val[PollW-1:0];
          CFG_START: start_r <= cfg_val[HoldW-1:0];
          CFG_BIT: bitph_r <= cfg_val[HoldW-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== hw/rtl/i2c_master_register_transfer.sv =====
// Path: an accepted word waits in a queue slot, then one bus-sequencer
// step writes it to the output register. Throughput: one word per cycle
// while out_ready holds, set by the single-step bus sequencer.
// Reset (rst_n low, synchronous): idle, SCL high, SDA high driven,
// timing registers back to 500 / 4 / 2, queue and output emptied.
module i2c_master_register_transfer (
  input logic clk,
  input logic rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);
  import i2cm_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_data;

  assign cfg_ch.ready = 1'b1;

  i2cm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  i2cm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_val(cfg_ch.wdata),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ===== tb/tb_i2c_master_register_transfer.sv =====
`timescale 1ns / 100ps

module tb_i2c_master_register_transfer;
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE, P_ST_A, P_ST_B, P_WB_SET, P_WB_HIGH, P_WB_LOW, P_ACK_REL, P_ACK_CLK,
    P_ACK_POLL, P_WAIT_DATA, P_RB_LOW, P_RB_HIGH, P_RA_SET, P_RA_HIGH, P_SP_A,
    P_SP_B, P_ERR_WAIT
  } bus_phase_e;

  localparam int StallLimit = 20000;
  localparam int HoldOffCycles = 300;
  localparam logic [3:0] ErrPauseTicks = 4'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  i2cm_in_if in_if ();
  i2cm_out_if out_if ();
  i2cm_cfg_if cfg_if ();

  i2c_master_register_transfer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if.sink),
    .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  always #5 clk = ~clk;

  // bus model state
  logic [9:0] poll_limit;
  logic [3:0] start_hold, bit_hold;
  bus_phase_e ph;
  logic [3:0] bit_cnt, dly_cnt;
  logic [9:0] poll_cnt;
  logic [7:0] shreg, bytes_left, dev_q;
  logic [15:0] reg_q;
  logic [1:0] flags_q;
  logic [2:0] lines;
  int stage;
  logic err_q;

  out_word_t bus_words_q[$];
  int fails = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic logic [3:0] nz(logic [3:0] v);
    return (v != 0) ? v : 4'd1;
  endfunction

  function automatic void set_lines(logic scl, logic sda, logic drv);
    lines = {drv, sda, scl};
  endfunction

  function automatic void enter(bus_phase_e p);
    logic [3:0] d;
    logic sda, drv;
    d = 1;
    sda = lines[1];
    drv = lines[2];
    ph = p;
    case (p)
      P_ST_A: begin set_lines(1, 1, 1); d = nz(start_hold); end
      P_ST_B: begin set_lines(1, 0, 1); d = nz(start_hold); end
      P_WB_SET: begin set_lines(0, shreg[7], 1); d = nz(bit_hold); end
      P_WB_HIGH: begin set_lines(1, sda, drv); d = nz(bit_hold); end
      P_WB_LOW: begin set_lines(0, sda, drv); d = nz(bit_hold); end
      P_ACK_REL: set_lines(0, 1, 0);
      P_ACK_CLK: set_lines(1, 1, 0);
      P_ACK_POLL: poll_cnt = 0;
      P_WAIT_DATA: set_lines(0, 1, 0);
      P_RB_LOW: begin set_lines(0, 1, 0); d = nz(bit_hold); end
      P_RB_HIGH: set_lines(1, 1, 0);
      P_RA_SET: begin set_lines(0, bytes_left == 1, 1); d = nz(bit_hold); end
      P_RA_HIGH: begin set_lines(1, sda, drv); d = nz(bit_hold); end
      P_SP_A: begin set_lines(0, 0, 1); d = nz(start_hold); end
      P_SP_B: begin set_lines(1, 1, 1); d = nz(start_hold); end
      P_ERR_WAIT: d = ErrPauseTicks;
      default: begin ph = P_IDLE; set_lines(1, 1, 1); end
    endcase
    dly_cnt = d - 4'd1;
  endfunction

  function automatic void send_byte(logic [7:0] b, int stg);
    shreg = b;
    bit_cnt = 0;
    stage = stg;
    enter(P_WB_SET);
  endfunction

  function automatic void after_ack();
    case (stage)
      0: if (flags_q[1]) send_byte(reg_q[15:8], 1);
         else send_byte(reg_q[7:0], 2);
      1: send_byte(reg_q[7:0], 2);
      2: if (flags_q[0]) begin stage = 3; enter(P_ST_A); end
         else if (bytes_left != 0) begin stage = 4; enter(P_WAIT_DATA); end
         else enter(P_SP_A);
      3: begin bit_cnt = 0; shreg = 0; enter(P_RB_LOW); end
      default: begin
        bytes_left = bytes_left - 8'd1;
        if (bytes_left != 0) enter(P_WAIT_DATA);
        else enter(P_SP_A);
      end
    endcase
  endfunction

  function automatic void bus_reset();
    poll_limit = PollLimitReset;
    start_hold = StartHoldReset;
    bit_hold = BitPhaseReset;
    bit_cnt = 0; dly_cnt = 0; poll_cnt = 0; shreg = 0; bytes_left = 0;
    dev_q = 0; reg_q = 0; flags_q = 0; stage = 0; err_q = 0;
    enter(P_IDLE);
  endfunction

  function automatic out_word_t bus_step(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.kind == KIND_BEGIN && ph == P_IDLE) begin
      dev_q = w.dev_address;
      reg_q = w.reg_address;
      flags_q = {w.addr_two_bytes, w.is_read};
      bytes_left = w.length;
      if (flags_q[0] && bytes_left == 0) bytes_left = 1;
      err_q = 0;
      stage = 0;
      enter(P_ST_A);
    end else if (w.kind == KIND_SUPPLY && ph == P_WAIT_DATA) begin
      send_byte(w.wr_byte, 4);
    end else if (w.kind == KIND_TICK && ph != P_IDLE && ph != P_WAIT_DATA) begin
      if (ph == P_ACK_POLL) begin
        if (!w.sda_in) begin
          set_lines(0, 1, 0);
          after_ack();
        end else if (poll_cnt >= poll_limit) begin
          err_q = 1;
          enter(P_SP_A);
        end else begin
          poll_cnt = poll_cnt + 10'd1;
        end
      end else if (ph == P_RB_HIGH) begin
        shreg = {shreg[6:0], w.sda_in};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 8) begin
          r.rd_valid = 1;
          r.rd_byte = shreg;
          r.rd_last = bytes_left <= 1;
          enter(P_RA_SET);
        end else begin
          enter(P_RB_LOW);
        end
      end else if (dly_cnt != 0) begin
        dly_cnt = dly_cnt - 4'd1;
      end else begin
        case (ph)
          P_ST_A: enter(P_ST_B);
          P_ST_B: if (stage == 3) send_byte(dev_q | 8'h01, 3);
                  else send_byte(dev_q, 0);
          P_WB_SET: enter(P_WB_HIGH);
          P_WB_HIGH: enter(P_WB_LOW);
          P_WB_LOW: begin
            shreg = {shreg[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            enter(bit_cnt >= 8 ? P_ACK_REL : P_WB_SET);
          end
          P_ACK_REL: enter(P_ACK_CLK);
          P_ACK_CLK: enter(P_ACK_POLL);
          P_RB_LOW: enter(P_RB_HIGH);
          P_RA_SET: enter(P_RA_HIGH);
          P_RA_HIGH: begin
            if (bytes_left != 0) bytes_left = bytes_left - 8'd1;
            if (bytes_left != 0) begin bit_cnt = 0; shreg = 0; enter(P_RB_LOW); end
            else enter(P_SP_A);
          end
          P_SP_A: enter(P_SP_B);
          P_SP_B: begin
            if (err_q) enter(P_ERR_WAIT);
            else begin r.done_res = 1; enter(P_IDLE); end
          end
          default: begin
            r.done_res = 1; r.status = 1; err_q = 0; enter(P_IDLE);
          end
        endcase
      end
    end
    r.scl_level = lines[0];
    r.sda_level = lines[1];
    r.sda_drive = lines[2];
    r.need_write_byte = ph == P_WAIT_DATA;
    r.busy_res = ph != P_IDLE;
    return r;
  endfunction

  // ---------------- driving ----------------
  task automatic push_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk); while (!in_if.ready);
    bus_words_q.push_back(bus_step(w));
    words_sent++;
  endtask

  function automatic in_word_t rand_word(logic [1:0] kind);
    in_word_t w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.kind = kind;
    return w;
  endfunction

  task automatic push_tick(logic sda);
    in_word_t w;
    w = rand_word(KIND_TICK);
    w.sda_in = sda;
    push_word(w);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (bus_words_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_POLL: poll_limit = val[9:0];
      CFG_START: start_hold = val[3:0];
      default: bit_hold = val[3:0];
    endcase
  endtask

  task automatic set_timing(logic [15:0] poll, logic [15:0] st, logic [15:0] bt);
    write_reg(CFG_POLL, poll);
    write_reg(CFG_START, st);
    write_reg(CFG_BIT, bt);
  endtask

  // one register transfer; no_ack holds SDA high on every acknowledge poll
  task automatic run_transfer(logic rd, logic [7:0] dev, logic [15:0] regaddr,
                              logic two, logic [7:0] len, bit no_ack, bit noisy);
    in_word_t w;
    w = rand_word(KIND_BEGIN);
    w.is_read = rd;
    w.dev_address = dev;
    w.reg_address = regaddr;
    w.addr_two_bytes = two;
    w.length = len;
    push_word(w);
    while (ph != P_IDLE) begin
      if (noisy && $urandom_range(19) == 0) begin
        case ($urandom_range(2))
          0: push_word(rand_word(2'd3));
          1: push_word(rand_word(KIND_BEGIN));
          default: push_word(rand_word(ph == P_WAIT_DATA ? KIND_TICK : KIND_SUPPLY));
        endcase
      end else if (ph == P_WAIT_DATA) begin
        push_word(rand_word(KIND_SUPPLY));
      end else if (ph == P_ACK_POLL) begin
        push_tick(no_ack ? 1'b1 : ($urandom_range(7) == 0));
      end else begin
        push_tick(1'($urandom_range(1)));
      end
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_idle_noise();
    push_tick(1'b0);
    push_tick(1'b1);
    push_word(rand_word(KIND_SUPPLY));
    push_word(rand_word(2'd3));
  endtask

  task automatic test_default_timing();
    run_transfer(1'b0, 8'hA0, 16'h1234, 1'b0, 8'd0, 1'b0, 1'b0);
  endtask

  task automatic test_length_extremes();
    set_timing(16'd1023, 16'd0, 16'd0);
    run_transfer(1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'd0, 1'b0, 1'b0);
    run_transfer(1'b1, 8'h5A, 16'h0000, 1'b0, 8'd0, 1'b0, 1'b0);
  endtask

  task automatic test_slow_timing();
    set_timing(16'd0, 16'd15, 16'd1);
    run_transfer(1'b0, 8'h3C, 16'hC3C3, 1'b1, 8'd1, 1'b1, 1'b0);
  endtask

  task automatic test_ack_timeout();
    set_timing(16'd0, 16'd1, 16'd1);
    run_transfer(1'b0, 8'h42, 16'h0042, 1'b0, 8'd3, 1'b1, 1'b0);
    write_reg(CFG_POLL, 16'hFC05);
    run_transfer(1'b1, 8'h42, 16'h0042, 1'b1, 8'd3, 1'b1, 1'b0);
  endtask

  task automatic run_random(int target);
    logic [7:0] len;
    while (words_sent < target) begin
      len = 8'($urandom_range(3));
      run_transfer(1'($urandom_range(1)), 8'($urandom), 16'($urandom),
                   1'($urandom_range(1)), len, $urandom_range(9) == 0, 1'b1);
      repeat ($urandom_range(2)) push_tick(1'($urandom_range(1)));
    end
  endtask

  task automatic test_random();
    int base;
    int pct[4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{34, 34}};
    base = words_sent;
    for (int i = 0; i < 4; i++) begin
      set_timing(16'($urandom_range(6)), 16'($urandom_range(1)), 16'($urandom_range(1)));
      send_idle_pct = pct[i][0];
      recv_stall_pct = pct[i][1];
      if (i == 0) hold_req = ~hold_req;
      run_random(base + (i + 1) * 50);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldOffCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $error("%s expected %0h got %0h", name, expv, actv);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e, a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.data;
      if (bus_words_q.size() == 0) begin
        $error("unexpected result word %h", a);
        fails++;
      end else begin
        e = bus_words_q.pop_front();
        check_field("scl_level", e.scl_level, a.scl_level);
        check_field("sda_level", e.sda_level, a.sda_level);
        check_field("sda_drive", e.sda_drive, a.sda_drive);
        check_field("need_write_byte", e.need_write_byte, a.need_write_byte);
        check_field("rd_valid", e.rd_valid, a.rd_valid);
        check_field("rd_byte", e.rd_byte, a.rd_byte);
        check_field("rd_last", e.rd_last, a.rd_last);
        check_field("done_res", e.done_res, a.done_res);
        check_field("status", e.status, a.status);
        check_field("busy_res", e.busy_res, a.busy_res);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_POLL;
    cfg_if.wdata = '0;
    bus_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_noise();
    test_default_timing();
    test_length_extremes();
    test_slow_timing();
    test_ack_timeout();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
